[rtl/mean_variance_average_pool_assert.svh]
// Assertion macros shared by the pooling block.
`ifndef MEAN_VARIANCE_AVERAGE_POOL_ASSERT_SVH
`define MEAN_VARIANCE_AVERAGE_POOL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MVAP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVAP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/mvap_pkg.sv]
package mvap_pkg;

   // Default sizes
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_MAX_KERNEL = 8;

   // Fixed field widths
   localparam int PIX_W     = 16;
   localparam int IDX_W     = 10;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 56;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 11;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_WIDTH  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIDE_HEIGHT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDING       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_FLAGS    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT  = 4'd7;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW,
      ST_COL,
      ST_SUM,
      ST_SUMEND,
      ST_MUL1,
      ST_MUL2,
      ST_DIVM,
      ST_DIVV,
      ST_EMIT,
      ST_FINISH
   } mvap_state_type;

   // Window tracker controls for one axis
   typedef struct packed {
      logic base_clear;
      logic base_step;
      logic iter_load;
      logic iter_next;
   } mvap_axis_ctrl_type;

endpackage

[rtl/mvap_axis.sv]
// Tracks the pooling windows along one axis. The base points at the first
// window not yet finished; the iterator walks the windows that end at pos.
module mvap_axis import mvap_pkg::*; #(
   parameter int MAXN = DEF_MAX_WIDTH,
   parameter int MAXK = DEF_MAX_KERNEL,
   localparam int NW = $clog2(MAXN + 1),
   localparam int KW = $clog2(MAXK + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  mvap_axis_ctrl_type ctrl,
   input  logic [NW-1:0]      n,
   input  logic [KW-1:0]      k,
   input  logic [3:0]         s,
   input  logic [3:0]         p,
   input  logic               round_up,
   input  logic [NW-1:0]      pos,
   output logic               hit,
   output logic [IDX_W-1:0]   idx,
   output logic [NW-1:0]      lo,
   output logic [NW-1:0]      hi,
   output logic [KW-1:0]      extent,
   output logic [KW-1:0]      psize
);

   localparam int GW = NW + 4;
   localparam int IW = NW + 1;

   logic signed [GW-1:0] n_s, k_s, s_s, p_s, pos_s;
   logic signed [GW-1:0] base_is_ff, it_is_ff;
   logic [IW-1:0]        base_idx_ff, it_idx_ff;
   logic signed [GW-1:0] base_en, lim, st, en, lo_s, hi_s, endc;

   assign n_s   = GW'(n);
   assign k_s   = GW'(k);
   assign s_s   = GW'(s);
   assign p_s   = GW'(p);
   assign pos_s = GW'(pos);

   // base window end, and the last valid window start offset
   assign base_en = base_is_ff - p_s + k_s;
   assign lim = round_up ? n_s - k_s + p_s + p_s + s_s - GW'(1) : n_s - k_s + p_s + p_s;

   // geometry of the iterator window
   assign st   = it_is_ff - p_s;
   assign en   = st + k_s;
   assign lo_s = (st > 0) ? st : '0;
   assign hi_s = (en < n_s) ? en : n_s;
   assign endc = (en < n_s + p_s) ? en : n_s + p_s;

   assign hit = (it_is_ff <= lim) && (st < n_s) &&
                ((pos_s == n_s - GW'(1)) ? (en >= n_s) : (en == pos_s + GW'(1)));
   assign idx    = IDX_W'(it_idx_ff);
   assign lo     = NW'(lo_s);
   assign hi     = NW'(hi_s);
   assign extent = KW'(hi_s - lo_s);
   assign psize  = KW'(endc - st);

   // base and iterator
   always_ff @(posedge clock) begin
      if (reset) begin
         base_is_ff  <= '0;
         base_idx_ff <= '0;
         it_is_ff    <= '0;
         it_idx_ff   <= '0;
      end else begin
         if (ctrl.base_clear) begin
            base_is_ff  <= '0;
            base_idx_ff <= '0;
         end else if (ctrl.base_step && (base_en == pos_s + GW'(1))) begin
            base_is_ff  <= base_is_ff + s_s;
            base_idx_ff <= base_idx_ff + 1'b1;
         end
         if (ctrl.iter_load) begin
            it_is_ff  <= base_is_ff;
            it_idx_ff <= base_idx_ff;
         end else if (ctrl.iter_next) begin
            it_is_ff  <= it_is_ff + s_s;
            it_idx_ff <= it_idx_ff + 1'b1;
         end
      end
   end

endmodule

[rtl/mvap_div.sv]
// Restoring divider, one quotient bit per cycle.
module mvap_div import mvap_pkg::*; #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int CW = $clog2(NUM_W + 1);

   logic             busy_ff, done_ff;
   logic [CW-1:0]    cnt_ff;
   logic [DEN_W-1:0] den_ff, rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W:0]   rem_sh, rem_sub;
   logic             ge;

   assign rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         den_ff <= divisor;
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= ge ? DEN_W'(rem_sub) : DEN_W'(rem_sh);
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/mean_variance_average_pool.sv]
// Average pooling of (mean, variance) Q8.8 pixel pairs in raster order. The
// block takes one pixel when idle and then works through every pooling window
// that this pixel completes, one window at a time, on a single sum, multiply
// and divide path; it is not ready again until the last result of the pixel
// has been handed to the output register. Each completed window is summed one
// line-buffer read per cycle, then one restoring divider is used twice, for
// the mean and for the variance. The line buffer needs no clearing pass. Any
// register write restarts the plane at row 0, column 0.
`include "mean_variance_average_pool_assert.svh"

module mean_variance_average_pool import mvap_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int MAX_KERNEL = DEF_MAX_KERNEL
) (
   input  logic                   clock,
   input  logic                   reset,
   // item in
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // mean_in[15:0], variance_in[31:16]
   // item out
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // mean_out[15:0], variance_out[31:16],
                                              // out_row[41:32], out_col[51:42]
   output logic                   rsp_tlast,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int KW   = $clog2(MAX_KERNEL + 1);
   localparam int SW   = $clog2(MAX_KERNEL);
   localparam int CXW  = $clog2(MAX_WIDTH + 1);
   localparam int RYW  = $clog2(MAX_HEIGHT + 1);
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int SMW  = PIX_W + 2 * KW;
   localparam int DVW  = SMW + 2;
   localparam int DW   = 2 * KW;
   localparam int D2W  = 4 * KW;
   localparam int DSW  = D2W + 1;

   // configuration registers
   logic [3:0]  kernel_width_ff, kernel_height_ff, stride_width_ff, stride_height_ff;
   logic [7:0]  padding_ff;
   logic [1:0]  mode_flags_ff;
   logic [10:0] image_width_ff, image_height_ff;
   logic        csr_hit;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index <= CSR_IMAGE_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_width_ff  <= 4'd2;
         kernel_height_ff <= 4'd2;
         stride_width_ff  <= 4'd2;
         stride_height_ff <= 4'd2;
         padding_ff       <= '0;
         mode_flags_ff    <= '0;
         image_width_ff   <= 11'd1;
         image_height_ff  <= 11'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_data[3:0];
            CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_data[3:0];
            CSR_STRIDE_WIDTH:  stride_width_ff  <= csr_data[3:0];
            CSR_STRIDE_HEIGHT: stride_height_ff <= csr_data[3:0];
            CSR_PADDING:       padding_ff       <= csr_data[7:0];
            CSR_MODE_FLAGS:    mode_flags_ff    <= csr_data[1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data;
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // clamped geometry
   logic [KW-1:0]  kw, kh;
   logic [3:0]     sw, sh, pw, ph;
   logic [CXW-1:0] w;
   logic [RYW-1:0] h;

   assign kw = (kernel_width_ff == '0) ? KW'(1) :
               (int'(kernel_width_ff) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_width_ff);
   assign kh = (kernel_height_ff == '0) ? KW'(1) :
               (int'(kernel_height_ff) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_height_ff);
   assign sw = (stride_width_ff == '0) ? 4'd1 : stride_width_ff;
   assign sh = (stride_height_ff == '0) ? 4'd1 : stride_height_ff;
   assign pw = (int'(padding_ff[3:0]) > int'(kw >> 1)) ? 4'(kw >> 1) : padding_ff[3:0];
   assign ph = (int'(padding_ff[7:4]) > int'(kh >> 1)) ? 4'(kh >> 1) : padding_ff[7:4];
   assign w  = (image_width_ff == '0) ? CXW'(1) :
               (int'(image_width_ff) > MAX_WIDTH) ? CXW'(MAX_WIDTH) : CXW'(image_width_ff);
   assign h  = (image_height_ff == '0) ? RYW'(1) :
               (int'(image_height_ff) > MAX_HEIGHT) ? RYW'(MAX_HEIGHT) : RYW'(image_height_ff);

   // sequencer signals
   mvap_state_type     state_ff, state_in;
   mvap_axis_ctrl_type row_ctrl, col_ctrl;
   logic req_acc, rsp_free, sum_init, sum_issue, sum_last;
   logic mul1_en, mul2_en, div_start, div_sel_var, mean_cap, var_cap;
   logic emit_go, fin_go, rsp_push, push_last;
   logic div_busy, div_done;
   logic [DVW-1:0] div_quo;

   // pixel position
   logic [CXW-1:0] col_ff;
   logic [RYW-1:0] row_ff;
   logic [SW-1:0]  slot_ff;
   logic           col_end, row_end;

   assign col_end = (col_ff == w - 1'b1);
   assign row_end = (row_ff == h - 1'b1);
   assign req_acc = req_tvalid && req_tready;

   // window trackers
   logic             row_hit, col_hit;
   logic [IDX_W-1:0] row_idx, col_idx;
   logic [RYW-1:0]   row_lo, row_hi;
   logic [CXW-1:0]   col_lo, col_hi;
   logic [KW-1:0]    row_ext, row_psz, col_ext, col_psz;

   mvap_axis #(.MAXN(MAX_HEIGHT), .MAXK(MAX_KERNEL)) u_row_axis (
      .clock(clock), .reset(reset), .ctrl(row_ctrl),
      .n(h), .k(kh), .s(sh), .p(ph), .round_up(mode_flags_ff[0]), .pos(row_ff),
      .hit(row_hit), .idx(row_idx), .lo(row_lo), .hi(row_hi),
      .extent(row_ext), .psize(row_psz)
   );

   mvap_axis #(.MAXN(MAX_WIDTH), .MAXK(MAX_KERNEL)) u_col_axis (
      .clock(clock), .reset(reset), .ctrl(col_ctrl),
      .n(w), .k(kw), .s(sw), .p(pw), .round_up(mode_flags_ff[0]), .pos(col_ff),
      .hit(col_hit), .idx(col_idx), .lo(col_lo), .hi(col_hi),
      .extent(col_ext), .psize(col_psz)
   );

   // line buffer: {variance, mean}
   logic [2*PIX_W-1:0] line_mem [MAX_KERNEL][MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_data_ff;
   logic               rd_vld_ff;
   logic [RYW-1:0]     y_ff;
   logic [CXW-1:0]     x_ff;
   logic [SW-1:0]      slot_dist, rd_slot;
   logic [RYW-1:0]     row_diff;

   assign row_diff  = row_ff - y_ff;
   assign slot_dist = SW'(row_diff);
   assign rd_slot   = (slot_ff >= slot_dist) ? slot_ff - slot_dist :
                      SW'({1'b0, slot_ff} + (SW+1)'(MAX_KERNEL) - {1'b0, slot_dist});
   assign sum_last  = (x_ff + 1'b1 == col_hi) && (y_ff + 1'b1 == row_hi);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         line_mem[slot_ff][col_ff[XW-1:0]] <= req_tdata;
      end
      if (sum_issue) begin
         rd_data_ff <= line_mem[rd_slot][x_ff[XW-1:0]];
      end
   end

   // window scan and sums
   logic signed [SMW-1:0] smean_ff;
   logic [SMW-1:0]        svar_ff, mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= sum_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (sum_init) begin
         y_ff     <= row_lo;
         x_ff     <= col_lo;
         smean_ff <= '0;
         svar_ff  <= '0;
      end else begin
         if (sum_issue) begin
            if (x_ff + 1'b1 == col_hi) begin
               x_ff <= col_lo;
               y_ff <= y_ff + 1'b1;
            end else begin
               x_ff <= x_ff + 1'b1;
            end
         end
         if (rd_vld_ff) begin
            smean_ff <= smean_ff + SMW'(signed'(rd_data_ff[PIX_W-1:0]));
            svar_ff  <= svar_ff + SMW'(rd_data_ff[2*PIX_W-1:PIX_W]);
         end
      end
   end

   assign mag = smean_ff[SMW-1] ? SMW'(-smean_ff) : SMW'(smean_ff);

   // divisor and its square
   logic [DW-1:0]  div_ff, div_prod;
   logic [D2W-1:0] d2_ff;

   assign div_prod = mode_flags_ff[1] ? DW'(row_psz * col_psz) : DW'(row_ext * col_ext);

   always_ff @(posedge clock) begin
      if (mul1_en) begin
         div_ff <= (div_prod == '0) ? DW'(1) : div_prod;
      end
      if (mul2_en) begin
         d2_ff <= D2W'(div_ff * div_ff);
      end
   end

   // shared divider: rounded quotient = (2x + d) / 2d
   logic [DVW-1:0] dvd;
   logic [DSW-1:0] dsr;

   assign dvd = div_sel_var ? (DVW'(svar_ff) << 1) + DVW'(d2_ff)
                            : (DVW'(mag) << 1) + DVW'(div_ff);
   assign dsr = div_sel_var ? DSW'(d2_ff) << 1 : DSW'(div_ff) << 1;

   mvap_div #(.NUM_W(DVW), .DEN_W(DSW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(dvd), .divisor(dsr),
      .busy(div_busy), .done(div_done), .quotient(div_quo)
   );

   // saturate results
   logic [PIX_W-1:0] mean_res_ff, var_res_ff, mean_sat, var_sat;

   assign mean_sat = smean_ff[SMW-1]
      ? ((div_quo > DVW'(32768)) ? 16'h8000 : PIX_W'(-div_quo))
      : ((div_quo > DVW'(32767)) ? 16'h7fff : PIX_W'(div_quo));
   assign var_sat  = (div_quo > DVW'(65535)) ? 16'hffff : PIX_W'(div_quo);

   always_ff @(posedge clock) begin
      if (mean_cap) mean_res_ff <= mean_sat;
      if (var_cap)  var_res_ff  <= var_sat;
   end

   // pending result, held until we know whether it is the pixel's last
   logic                   pend_vld_ff;
   logic [RSP_TDATA_W-1:0] pend_data_ff;
   logic                   rsp_tvalid_ff, rsp_tlast_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   assign rsp_free = !rsp_tvalid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_vld_ff <= 1'b0;
      end else if (emit_go) begin
         pend_vld_ff <= 1'b1;
      end else if (fin_go) begin
         pend_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         pend_data_ff <= {4'b0, col_idx, row_idx, var_res_ff, mean_res_ff};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_push) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rsp_tdata_ff <= pend_data_ff;
         rsp_tlast_ff <= push_last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // position advance
   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (fin_go) begin
         if (col_end) begin
            col_ff <= '0;
            if (row_end) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= row_ff + 1'b1;
               slot_ff <= (slot_ff == SW'(MAX_KERNEL - 1)) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_acc) state_in = ST_ROW;
         ST_ROW:    state_in = row_hit ? ST_COL : ST_FINISH;
         ST_COL:    state_in = col_hit ? ST_SUM : ST_ROW;
         ST_SUM:    if (sum_last) state_in = ST_SUMEND;
         ST_SUMEND: state_in = ST_MUL1;
         ST_MUL1:   state_in = ST_MUL2;
         ST_MUL2:   state_in = ST_DIVM;
         ST_DIVM:   if (div_done) state_in = ST_DIVV;
         ST_DIVV:   if (div_done) state_in = ST_EMIT;
         ST_EMIT:   if (!pend_vld_ff || rsp_free) state_in = ST_COL;
         ST_FINISH: if (!pend_vld_ff || rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      row_ctrl    = '0;
      col_ctrl    = '0;
      sum_init    = 1'b0;
      sum_issue   = 1'b0;
      mul1_en     = 1'b0;
      mul2_en     = 1'b0;
      div_start   = 1'b0;
      div_sel_var = 1'b0;
      mean_cap    = 1'b0;
      var_cap     = 1'b0;
      emit_go     = 1'b0;
      fin_go      = 1'b0;
      rsp_push    = 1'b0;
      push_last   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready         = !pend_vld_ff;
            row_ctrl.iter_load = req_acc;
         end
         ST_ROW: begin
            col_ctrl.iter_load = row_hit;
         end
         ST_COL: begin
            sum_init           = col_hit;
            row_ctrl.iter_next = !col_hit;
         end
         ST_SUM:  sum_issue = 1'b1;
         ST_MUL1: mul1_en   = 1'b1;
         ST_MUL2: begin
            mul2_en   = 1'b1;
            div_start = 1'b1;
         end
         ST_DIVM: begin
            mean_cap    = div_done;
            div_start   = div_done;
            div_sel_var = 1'b1;
         end
         ST_DIVV: begin
            var_cap = div_done;
         end
         ST_EMIT: begin
            if (!pend_vld_ff || rsp_free) begin
               emit_go            = 1'b1;
               col_ctrl.iter_next = 1'b1;
               rsp_push           = pend_vld_ff;
            end
         end
         ST_FINISH: begin
            if (!pend_vld_ff || rsp_free) begin
               fin_go              = 1'b1;
               rsp_push            = pend_vld_ff;
               push_last           = 1'b1;
               col_ctrl.base_clear = col_end;
               col_ctrl.base_step  = !col_end;
               row_ctrl.base_clear = col_end && row_end;
               row_ctrl.base_step  = col_end && !row_end;
            end
         end
         default: ;
      endcase
      if (csr_hit) begin
         row_ctrl.base_clear = 1'b1;
         col_ctrl.base_clear = 1'b1;
      end
   end

   // checks
   `MVAP_ASSERT_NOW(a_ready_no_pending, req_tready, !pend_vld_ff && (state_ff == ST_IDLE),
      "input taken while a result is pending")
   `MVAP_ASSERT_NOW(a_div_start_free, div_start, !div_busy,
      "divider restarted while busy")
   `MVAP_ASSERT_NEXT(a_accept_to_row, req_acc, state_ff == ST_ROW,
      "accepted item did not start the row scan")

endmodule
